// File: hdl/clt_pkg.sv
// Shared types, character codes and sizes for the command-line tokenizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package clt_pkg;

   // Character codes the lexer reacts to.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   // One input byte yields at most this many results.
   localparam int MAX_RESULTS = 4;
   localparam int SEL_W       = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] next_ch;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       to_args;
      logic       to_redirect;
      logic       arg_start;
      logic       pipe_mark;
      logic       target_error;
      logic       last_of_run;
   } rsp_type;

   // All results of one input byte, handed from the front end to the back end.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] items;
      logic [SEL_W-1:0]          last_idx;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic rsp_type make_item(input logic [7:0] b, input logic a,
                                         input logic r, input logic p,
                                         input logic e);
      rsp_type it;
      it              = '0;
      it.out_byte     = b;
      it.to_args      = a;
      it.to_redirect  = r;
      it.pipe_mark    = p;
      it.target_error = e;
      return it;
   endfunction

endpackage

`default_nettype wire

// File: hdl/command_line_tokenizer_top.sv
// Top level of the command-line tokenizer: front end, bundle queue, back end.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
//
//   Channel   Ports                      Direction  Transfer when
//   request   push, full, req_item       in         push && !full
//   response  empty, pop, rsp_item       out        pop && !empty
//
// One byte is taken per cycle while the queue is not full. Its results are
// classified in the cycle it is taken, then pass through the bundle queue and
// the output register before they appear on rsp_item. The back end sends one
// result per cycle while pop is not stalled; QUEUE_DEPTH bundles absorb
// operator bursts before full rises. Reset clears the lexer mode, the skip flag,
// the queue and the output valid flag. A stalled pop stops the back end only;
// the front keeps taking bytes until the queue fills.
`default_nettype none

module command_line_tokenizer_top #(
   parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  clt_pkg::req_type  req_item,
   output logic              empty,
   input  wire               pop,
   output clt_pkg::rsp_type  rsp_item
);
   import clt_pkg::*;

   logic       bundle_push;
   bundle_type bundle;
   bundle_type head;
   qstat_type  qstat;
   logic       q_rd;

   clt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_full    (qstat.full),
      .req_item    (req_item),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   clt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_push),
      .wr_data (bundle),
      .rd_en   (q_rd),
      .rd_data (head),
      .status  (qstat)
   );

   clt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .q_rd     (q_rd),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

   assign full = qstat.full;

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("bundle queue reports full and empty together");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      bundle_push |-> !qstat.full)
      else $error("bundle pushed into a full queue");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.target_error) |->
         (rsp_item.last_of_run && rsp_item.out_byte == CH_NUL &&
          !rsp_item.to_redirect && !rsp_item.to_args))
      else $error("target error result carries stream data");

   a_pipe_alone: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.pipe_mark) |-> rsp_item.last_of_run)
      else $error("pipe mark is not the only result of its byte");

endmodule

`default_nettype wire

// File: hdl/clt_front.sv
// Front end: holds the lexer mode and classifies each accepted byte into a
// bundle of up to four results. Depends on clt_pkg.
`default_nettype none

module clt_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   input  wire                  req_full,
   input  clt_pkg::req_type     req_item,
   output logic                 bundle_push,
   output clt_pkg::bundle_type  bundle
);
   import clt_pkg::*;

   localparam logic [3:0] MODE_DEFAULT = 4'd0;
   localparam logic [3:0] MODE_SPACES  = 4'd1;
   localparam logic [3:0] MODE_BSLASH  = 4'd2;
   localparam logic [3:0] MODE_DQ      = 4'd3;
   localparam logic [3:0] MODE_SQ      = 4'd4;
   localparam logic [3:0] MODE_TLEAD   = 4'd5;
   localparam logic [3:0] MODE_TDEF    = 4'd6;
   localparam logic [3:0] MODE_TBSLASH = 4'd7;
   localparam logic [3:0] MODE_TDQ     = 4'd8;
   localparam logic [3:0] MODE_TSQ     = 4'd9;

   logic [3:0]                mode_ff, mode_in;
   logic                      skip_ff, skip_in;
   logic                      accept;
   logic                      start;
   logic                      do_default;
   logic                      two_byte;
   logic [RES_CNT_W-1:0]      n_cnt;
   logic [RES_CNT_W-1:0]      lidx;
   rsp_type [MAX_RESULTS-1:0] items_c;
   logic [7:0]                c, n;

   assign c        = req_item.ch;
   assign n        = req_item.next_ch;
   assign accept   = req_push && !req_full;
   assign two_byte = (c == CH_GT || c == CH_TWO || c == CH_AMP) && n == CH_GT;

   always_comb begin
      mode_in    = mode_ff;
      skip_in    = skip_ff;
      start      = 1'b0;
      do_default = 1'b0;
      n_cnt      = '0;
      items_c    = '0;
      lidx       = '0;

      if (skip_ff) begin
         skip_in = 1'b0;
      end else begin
         case (mode_ff)
            MODE_SPACES: begin
               if (c != CH_SPACE) begin
                  mode_in = MODE_DEFAULT;
                  if (c != CH_NUL) begin
                     start      = 1'b1;
                     do_default = 1'b1;
                  end
               end
            end
            MODE_BSLASH: begin
               items_c[0] = make_item(c, 1'b1, 1'b0, 1'b0, 1'b0);
               n_cnt      = RES_CNT_W'(1);
               mode_in    = MODE_DEFAULT;
            end
            MODE_DQ, MODE_SQ: begin
               items_c[0] = make_item(c, 1'b1, 1'b0, 1'b0, 1'b0);
               n_cnt      = RES_CNT_W'(1);
               if (c == CH_NUL || (mode_ff == MODE_DQ && c == CH_DQ) ||
                   (mode_ff == MODE_SQ && c == CH_SQ)) begin
                  mode_in = MODE_DEFAULT;
               end
            end
            MODE_TLEAD, MODE_TDEF, MODE_TBSLASH, MODE_TDQ, MODE_TSQ: begin
               if (c == CH_NUL) begin
                  // A missing target reports an error in place of a terminator.
                  if (mode_ff == MODE_TLEAD) begin
                     items_c[0] = make_item(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
                  end else begin
                     items_c[0] = make_item(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                  end
                  n_cnt   = RES_CNT_W'(1);
                  mode_in = MODE_DEFAULT;
               end else if (c == CH_SPACE && mode_ff == MODE_TLEAD) begin
                  mode_in = MODE_TLEAD;
               end else if (c == CH_SPACE || c == CH_NL) begin
                  items_c[0] = make_item(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  mode_in    = MODE_DEFAULT;
               end else if (mode_ff == MODE_TBSLASH) begin
                  items_c[0] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  mode_in    = MODE_TDEF;
               end else if (mode_ff == MODE_TDQ || mode_ff == MODE_TSQ) begin
                  items_c[0] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  if ((mode_ff == MODE_TDQ && c == CH_DQ) ||
                      (mode_ff == MODE_TSQ && c == CH_SQ)) begin
                     mode_in = MODE_TDEF;
                  end
               end else if (c == CH_BSL) begin
                  mode_in = MODE_TBSLASH;
               end else if (c == CH_DQ) begin
                  items_c[0] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  mode_in    = MODE_TDQ;
               end else if (c == CH_SQ) begin
                  items_c[0] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  mode_in    = MODE_TSQ;
               end else if (two_byte || c == CH_GT || c == CH_LT) begin
                  // An unquoted operator closes the target and starts a new one.
                  items_c[0] = make_item(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  do_default = 1'b1;
               end else begin
                  items_c[0] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
                  n_cnt      = RES_CNT_W'(1);
                  mode_in    = MODE_TDEF;
               end
            end
            default: begin
               do_default = 1'b1;
            end
         endcase

         if (do_default) begin
            if (c == CH_SPACE || c == CH_NL) begin
               items_c[n_cnt[SEL_W-1:0]] = make_item(CH_NUL, 1'b1, 1'b0, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               mode_in = MODE_SPACES;
            end else if (c == CH_BSL) begin
               mode_in = MODE_BSLASH;
            end else if (c == CH_DQ || c == CH_SQ) begin
               items_c[n_cnt[SEL_W-1:0]] = make_item(c, 1'b1, 1'b0, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               mode_in = (c == CH_DQ) ? MODE_DQ : MODE_SQ;
            end else if (two_byte) begin
               items_c[n_cnt[SEL_W-1:0]] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               items_c[n_cnt[SEL_W-1:0]] = make_item(n, 1'b0, 1'b1, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               items_c[n_cnt[SEL_W-1:0]] = make_item(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               skip_in = 1'b1;
               mode_in = MODE_TLEAD;
            end else if (c == CH_GT || c == CH_LT) begin
               items_c[n_cnt[SEL_W-1:0]] = make_item(c, 1'b0, 1'b1, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               items_c[n_cnt[SEL_W-1:0]] = make_item(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               mode_in = MODE_TLEAD;
            end else if (c == CH_PIPE) begin
               items_c[n_cnt[SEL_W-1:0]] = make_item(CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               mode_in = MODE_DEFAULT;
            end else begin
               items_c[n_cnt[SEL_W-1:0]] = make_item(c, 1'b1, 1'b0, 1'b0, 1'b0);
               n_cnt   = n_cnt + RES_CNT_W'(1);
               mode_in = MODE_DEFAULT;
            end
         end

         // A new argument that begins with a backslash still needs its mark.
         if (start && n_cnt == '0) begin
            items_c[0] = make_item(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0);
            n_cnt      = RES_CNT_W'(1);
         end
         if (start) begin
            items_c[0].arg_start = 1'b1;
         end
         if (n_cnt != '0) begin
            lidx = n_cnt - RES_CNT_W'(1);
            items_c[lidx[SEL_W-1:0]].last_of_run = 1'b1;
         end
      end
   end

   assign bundle_push     = accept && (n_cnt != '0);
   assign bundle.items    = items_c;
   assign bundle.last_idx = lidx[SEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DEFAULT;
         skip_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         skip_ff <= skip_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/clt_queue.sv
// Short queue of result bundles between the front and back ends.
// Depends on clt_pkg for the bundle and status types.
`default_nettype none

module clt_queue #(
   parameter int DEPTH = clt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_en,
   input  clt_pkg::bundle_type  wr_data,
   input  wire                  rd_en,
   output clt_pkg::bundle_type  rd_data,
   output clt_pkg::qstat_type   status
);
   import clt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type             store_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_wr, do_rd;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_data      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/clt_back.sv
// Back end: walks the head bundle one result per cycle, while pop does not stall
// it, into the output register. Depends on clt_pkg.
`default_nettype none

module clt_back (
   input  wire                  clock,
   input  wire                  reset,
   input  clt_pkg::bundle_type  head,
   input  clt_pkg::qstat_type   qstat,
   output logic                 q_rd,
   input  wire                  pop,
   output logic                 empty,
   output clt_pkg::rsp_type     rsp_item
);
   import clt_pkg::*;

   logic [SEL_W-1:0] sel_ff, sel_in;
   logic             valid_ff, valid_in;
   rsp_type          out_ff, out_in;
   logic             load;

   // The output register takes a new result when it is free or being taken.
   assign load = !valid_ff || pop;
   assign q_rd = load && !qstat.empty && (sel_ff == head.last_idx);

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         valid_in = !qstat.empty;
         if (!qstat.empty) begin
            out_in = head.items[sel_ff];
            sel_in = (sel_ff == head.last_idx) ? '0 : sel_ff + SEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty    = !valid_ff;
   assign rsp_item = out_ff;

endmodule

`default_nettype wire
